@@ hw/rtl/ict_pkg.sv @@
package ict_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned DEV_W     = 8;
  localparam int unsigned INO_W     = 20;
  localparam int unsigned SLOT_IN_W = 6;
  localparam int unsigned START_W   = 16;
  localparam int unsigned BLK_W     = 18;
  localparam int unsigned CNT_W     = 8;

  // Inodes are packed this many to a disk block.
  localparam int unsigned INODES_PER_BLOCK = 8;
  localparam int unsigned OFF_W            = $clog2(INODES_PER_BLOCK);

  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // A classified request as it travels from the front end to the table engine.
  typedef struct packed {
    logic                 req_type;
    logic [DEV_W-1:0]     dev;
    logic [INO_W-1:0]     ino;
    logic [SLOT_IN_W-1:0] slot;
    logic                 oob;
    logic                 mark;
    logic [BLK_W-1:0]     blk;
    logic [OFF_W-1:0]     off;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [SLOT_IN_W-1:0] result_slot;
    logic                 hit;
    logic                 load_needed;
    logic                 table_full;
    logic                 write_back;
    logic                 slot_freed;
    logic                 put_error;
    logic [BLK_W-1:0]     disk_block;
    logic [OFF_W-1:0]     block_offset;
  } res_t;

  // Disk block of a one-based inode number; inode zero wraps to the last entry.
  function automatic logic [BLK_W-1:0] locate_blk(input logic [INO_W-1:0] ino,
                                                  input logic [START_W-1:0] start);
    logic [INO_W-1:0] z;
    z = ino - INO_W'(1);
    return BLK_W'(z >> OFF_W) + BLK_W'(start);
  endfunction

  // Position of the inode within its block.
  function automatic logic [OFF_W-1:0] locate_off(input logic [INO_W-1:0] ino);
    logic [INO_W-1:0] z;
    z = ino - INO_W'(1);
    return z[OFF_W-1:0];
  endfunction

endpackage

@@ hw/rtl/refcounted_inode_cache_table_unit.sv @@
// Reference-counted inode cache table.
// Requests arrive on the in_* channel (valid/ready). A get looks up a live
// slot by device and inode number and bumps its count, or claims the lowest
// free slot and reports the disk block and offset to load. A put drops the
// count of a slot, optionally marking it dirty, and reports write-back when a
// dirty slot frees. Every request yields exactly one result on out_* channel.
// The cfg_* channel writes the first block of the on-disk inode table; it is
// always ready. The user must write it only while no request is in flight;
// the block itself does not enforce this. The table engine carries out one
// request at a time, using the lookup, priority encode and count
// read-modify-write steps as each request needs them.
// A two-entry command queue lets the input side keep accepting while the
// engine works, and a result register lets the engine finish while the
// receiver stalls; a stalled result holds until taken, the engine then waits
// with its next result, and the queue fills and finally drops in_ready_o.
// Reset frees every slot, clears all dirty marks and sets the table start to
// zero; no clearing pass is needed.
module refcounted_inode_cache_table_unit #(
  parameter int unsigned SLOT_COUNT = ict_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ict_pkg::START_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ict_pkg::DEV_W-1:0]     device_id_i,
  input  logic [ict_pkg::INO_W-1:0]     inode_number_i,
  input  logic [ict_pkg::SLOT_IN_W-1:0] slot_index_i,
  input  logic                          mark_dirty_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ict_pkg::SLOT_IN_W-1:0] result_slot_o,
  output logic                          hit_o,
  output logic                          load_needed_o,
  output logic                          table_full_o,
  output logic                          write_back_o,
  output logic                          slot_freed_o,
  output logic                          put_error_o,
  output logic [ict_pkg::BLK_W-1:0]     disk_block_o,
  output logic [ict_pkg::OFF_W-1:0]     block_offset_o
);

  logic [ict_pkg::START_W-1:0] table_start_q;
  logic                        fifo_full;
  logic                        fifo_empty;
  logic                        push;
  logic                        pop;
  ict_pkg::cmd_t               push_cmd;
  ict_pkg::cmd_t               head_cmd;
  ict_pkg::res_t               res;

  // Inode table start register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_start_q <= '0;
    end else if (cfg_valid_i) begin
      table_start_q <= cfg_data_i;
    end
  end

  ict_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .device_id_i    (device_id_i),
    .inode_number_i (inode_number_i),
    .slot_index_i   (slot_index_i),
    .mark_dirty_i   (mark_dirty_i),
    .table_start_i  (table_start_q),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  ict_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (fifo_empty)
  );

  ict_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!fifo_empty),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (pop),
    .table_start_i (table_start_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res)
  );

  // Result fields onto their ports.
  assign result_slot_o  = res.result_slot;
  assign hit_o          = res.hit;
  assign load_needed_o  = res.load_needed;
  assign table_full_o   = res.table_full;
  assign write_back_o   = res.write_back;
  assign slot_freed_o   = res.slot_freed;
  assign put_error_o    = res.put_error;
  assign disk_block_o   = res.disk_block;
  assign block_offset_o = res.block_offset;

endmodule

@@ hw/rtl/ict_cmd_fifo.sv @@
module ict_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ict_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ict_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned Depth = ict_pkg::CMD_FIFO_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ict_pkg::cmd_t         entries_q [Depth];
  logic [PtrW-1:0]       wptr_q, wptr_d;
  logic [PtrW-1:0]       rptr_q, rptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = entries_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer and occupancy update, pointers wrap at the depth.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/ict_front.sv @@
module ict_front #(
  parameter int unsigned SLOT_COUNT = ict_pkg::SLOT_COUNT_DEF
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ict_pkg::DEV_W-1:0]     device_id_i,
  input  logic [ict_pkg::INO_W-1:0]     inode_number_i,
  input  logic [ict_pkg::SLOT_IN_W-1:0] slot_index_i,
  input  logic                          mark_dirty_i,
  input  logic [ict_pkg::START_W-1:0]   table_start_i,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output ict_pkg::cmd_t                 cmd_o
);

  // A transaction is taken whenever the command queue has room.
  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // Classify the request: range check for puts, load address for gets.
  always_comb begin
    cmd_o.req_type = req_type_i;
    cmd_o.dev      = device_id_i;
    cmd_o.ino      = inode_number_i;
    cmd_o.slot     = slot_index_i;
    cmd_o.oob      = (32'(slot_index_i) >= SLOT_COUNT);
    cmd_o.mark     = mark_dirty_i;
    cmd_o.blk      = ict_pkg::locate_blk(inode_number_i, table_start_i);
    cmd_o.off      = ict_pkg::locate_off(inode_number_i);
  end

endmodule

@@ hw/rtl/ict_back.sv @@
module ict_back #(
  parameter int unsigned SLOT_COUNT = ict_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  ict_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  input  logic [ict_pkg::START_W-1:0] table_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ict_pkg::res_t               res_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [SLOT_COUNT-1:0] vec_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOOK,
    B_FIND,
    B_HIT,
    B_PUT
  } state_e;

  // Index of the lowest set bit: isolate it with a two's complement add, then encode.
  function automatic slot_t lowest_idx(input vec_t v);
    vec_t  oh;
    slot_t idx;
    oh  = v & (~v + SLOT_COUNT'(1));
    idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (oh[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  // Control and output registers.
  state_e        state_q, state_d;
  ict_pkg::cmd_t cmd_q, cmd_d;
  vec_t          match_q, match_d;
  slot_t         free_idx_q, free_idx_d;
  logic          free_any_q, free_any_d;
  slot_t         idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  ict_pkg::res_t res_q, res_d;

  // Slot state: live and dirty bits in flops, tags as compare cells, counts in memory.
  vec_t                       live_q;
  vec_t                       dirty_q;
  logic [ict_pkg::DEV_W-1:0]  dev_tag_q [SLOT_COUNT];
  logic [ict_pkg::INO_W-1:0]  ino_tag_q [SLOT_COUNT];
  logic [ict_pkg::CNT_W-1:0]  cnt_mem   [SLOT_COUNT];
  logic [ict_pkg::INO_W-1:0]  ino_mem   [SLOT_COUNT];
  logic [ict_pkg::CNT_W-1:0]  cnt_rd_q;
  logic [ict_pkg::INO_W-1:0]  ino_rd_q;

  // Table update and read controls driven by the sequencer.
  logic                      tbl_we;
  slot_t                     tbl_idx;
  logic [ict_pkg::CNT_W-1:0] tbl_cnt;
  logic                      tbl_live;
  logic                      tbl_dirty;
  logic                      tbl_claim;
  logic                      rd_en;
  slot_t                     rd_idx;

  logic                      can_emit;
  logic                      emit;
  ict_pkg::res_t             res_n;
  slot_t                     put_idx;
  logic                      hit_any;
  slot_t                     hit_idx;
  logic [ict_pkg::CNT_W-1:0] cnt_dec;
  logic                      freed;
  logic                      dirty_now;

  assign can_emit = !out_valid_q || out_ready_i;
  assign put_idx  = SLOT_W'(cmd_q.slot);
  assign hit_any  = |match_q;
  assign hit_idx  = lowest_idx(match_q);
  assign cnt_dec  = cnt_rd_q - ict_pkg::CNT_W'(1);
  assign freed    = (cnt_dec == '0);
  assign dirty_now = dirty_q[put_idx] || cmd_q.mark;

  // Sequencer: one request at a time, lookup then update and report.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    match_d     = match_q;
    free_idx_d  = free_idx_q;
    free_any_d  = free_any_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    tbl_we      = 1'b0;
    tbl_idx     = idx_q;
    tbl_cnt     = '0;
    tbl_live    = 1'b0;
    tbl_dirty   = 1'b0;
    tbl_claim   = 1'b0;
    rd_en       = 1'b0;
    rd_idx      = idx_q;
    emit        = 1'b0;
    res_n       = '0;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = B_LOOK;
        end
      end

      B_LOOK: begin
        if (cmd_q.req_type == ict_pkg::REQ_GET) begin
          // Compare every live slot and pick the lowest free one.
          for (int i = 0; i < SLOT_COUNT; i++) begin
            match_d[i] = live_q[i] && (dev_tag_q[i] == cmd_q.dev) &&
                         (ino_tag_q[i] == cmd_q.ino);
          end
          free_idx_d = lowest_idx(~live_q);
          free_any_d = !(&live_q);
          state_d    = B_FIND;
        end else if (cmd_q.oob || !live_q[put_idx]) begin
          // Release of a free or nonexistent slot is reported and changes nothing.
          res_n.result_slot = cmd_q.slot;
          res_n.put_error   = 1'b1;
          if (can_emit) begin
            emit    = 1'b1;
            state_d = B_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_idx  = put_idx;
          state_d = B_PUT;
        end
      end

      B_FIND: begin
        if (hit_any) begin
          rd_en   = 1'b1;
          rd_idx  = hit_idx;
          idx_d   = hit_idx;
          state_d = B_HIT;
        end else if (free_any_q) begin
          // Miss: claim the free slot and report the load address.
          res_n.result_slot  = ict_pkg::SLOT_IN_W'(free_idx_q);
          res_n.load_needed  = 1'b1;
          res_n.disk_block   = cmd_q.blk;
          res_n.block_offset = cmd_q.off;
          if (can_emit) begin
            emit      = 1'b1;
            tbl_we    = 1'b1;
            tbl_idx   = free_idx_q;
            tbl_cnt   = ict_pkg::CNT_W'(1);
            tbl_live  = 1'b1;
            tbl_dirty = 1'b0;
            tbl_claim = 1'b1;
            state_d   = B_IDLE;
          end
        end else begin
          res_n.table_full = 1'b1;
          if (can_emit) begin
            emit    = 1'b1;
            state_d = B_IDLE;
          end
        end
      end

      B_HIT: begin
        // Bump the count, holding it at its maximum.
        res_n.result_slot = ict_pkg::SLOT_IN_W'(idx_q);
        res_n.hit         = 1'b1;
        if (can_emit) begin
          emit      = 1'b1;
          tbl_we    = 1'b1;
          tbl_idx   = idx_q;
          tbl_cnt   = (cnt_rd_q == ict_pkg::COUNT_MAX) ? cnt_rd_q
                                                       : cnt_rd_q + ict_pkg::CNT_W'(1);
          tbl_live  = 1'b1;
          tbl_dirty = dirty_q[idx_q];
          state_d   = B_IDLE;
        end
      end

      B_PUT: begin
        // Drop the count; a slot that frees while dirty asks for write-back.
        res_n.result_slot = cmd_q.slot;
        res_n.slot_freed  = freed;
        res_n.write_back  = freed && dirty_now;
        if (freed && dirty_now) begin
          res_n.disk_block   = ict_pkg::locate_blk(ino_rd_q, table_start_i);
          res_n.block_offset = ict_pkg::locate_off(ino_rd_q);
        end
        if (can_emit) begin
          emit      = 1'b1;
          tbl_we    = 1'b1;
          tbl_idx   = put_idx;
          tbl_cnt   = cnt_dec;
          tbl_live  = !freed;
          tbl_dirty = !freed && dirty_now;
          state_d   = B_IDLE;
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      res_d       = res_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cmd_q       <= '0;
      match_q     <= '0;
      free_idx_q  <= '0;
      free_any_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      match_q     <= match_d;
      free_idx_q  <= free_idx_d;
      free_any_q  <= free_any_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  // Live and dirty bits; reset frees every slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      dirty_q <= '0;
    end else if (tbl_we) begin
      live_q[tbl_idx]  <= tbl_live;
      dirty_q[tbl_idx] <= tbl_dirty;
    end
  end

  // Tag cells are written when a slot is claimed.
  always_ff @(posedge clk_i) begin
    if (tbl_claim) begin
      dev_tag_q[tbl_idx] <= cmd_q.dev;
      ino_tag_q[tbl_idx] <= cmd_q.ino;
    end
  end

  // Count and inode memories: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      cnt_mem[tbl_idx] <= tbl_cnt;
    end
    if (tbl_claim) begin
      ino_mem[tbl_idx] <= cmd_q.ino;
    end
    if (rd_en) begin
      cnt_rd_q <= cnt_mem[rd_idx];
      ino_rd_q <= ino_mem[rd_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // A full-table report only happens when every slot is live.
  a_full_means_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res_n.table_full |-> &live_q)
    else $error("table_full reported while a slot was free");

  // A claim never lands on a live slot.
  a_claim_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_claim |-> !live_q[tbl_idx])
    else $error("claim targeted a live slot");

  // The slot whose count is bumped on a hit is live.
  a_hit_slot_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_HIT |-> live_q[idx_q])
    else $error("hit on a free slot");

  // A release that reaches the update step names a live slot.
  a_put_slot_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_PUT |-> !cmd_q.oob && live_q[put_idx])
    else $error("release update on a free slot");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ict_pkg::*;

  localparam int unsigned SLOTS       = SLOT_COUNT_DEF;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned RANDOM_REQS = 330;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // Predicts the result of every accepted request and checks the results in order.
  class inode_cache_scoreboard;
    bit [CNT_W-1:0]   ref_cnt [SLOTS];
    bit [DEV_W-1:0]   dev_tag [SLOTS];
    bit [INO_W-1:0]   ino_tag [SLOTS];
    bit               dirty   [SLOTS];
    bit [START_W-1:0] table_start;
    res_t             expected_results [$];
    int unsigned      err_count;

    function new();
      foreach (ref_cnt[i]) begin
        ref_cnt[i] = '0;
        dev_tag[i] = '0;
        ino_tag[i] = '0;
        dirty[i]   = 1'b0;
      end
      table_start = '0;
      err_count   = 0;
    endfunction

    // Inodes are one-based and packed eight to a block; inode zero wraps around.
    function logic [BLK_W-1:0] block_of(logic [INO_W-1:0] ino);
      logic [INO_W-1:0] z;
      z = ino - INO_W'(1);
      return BLK_W'(z[INO_W-1:OFF_W]) + BLK_W'(table_start);
    endfunction

    function logic [OFF_W-1:0] offset_of(logic [INO_W-1:0] ino);
      logic [INO_W-1:0] z;
      z = ino - INO_W'(1);
      return z[OFF_W-1:0];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Picks a random slot that currently holds references, or -1 if none does.
    function int pick_live_slot();
      int live [$];
      foreach (ref_cnt[i]) if (ref_cnt[i] != 0) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    // Updates the table copy for one accepted request and queues its result.
    function void note_request(logic rt, logic [DEV_W-1:0] dev, logic [INO_W-1:0] ino,
                               logic [SLOT_IN_W-1:0] slot, logic mark);
      res_t r;
      int   found;
      int   free_slot;
      r         = '0;
      found     = -1;
      free_slot = -1;
      if (rt == REQ_GET) begin
        foreach (ref_cnt[i]) begin
          if (found < 0 && ref_cnt[i] != 0 && dev_tag[i] == dev && ino_tag[i] == ino)
            found = i;
          if (free_slot < 0 && ref_cnt[i] == 0) free_slot = i;
        end
        if (found >= 0) begin
          if (ref_cnt[found] != COUNT_MAX) ref_cnt[found] = ref_cnt[found] + 1'b1;
          r.result_slot = SLOT_IN_W'(found);
          r.hit         = 1'b1;
        end else if (free_slot >= 0) begin
          ref_cnt[free_slot] = CNT_W'(1);
          dirty[free_slot]   = 1'b0;
          dev_tag[free_slot] = dev;
          ino_tag[free_slot] = ino;
          r.result_slot      = SLOT_IN_W'(free_slot);
          r.load_needed      = 1'b1;
          r.disk_block       = block_of(ino);
          r.block_offset     = offset_of(ino);
        end else begin
          r.table_full = 1'b1;
        end
      end else begin
        r.result_slot = slot;
        if (ref_cnt[slot] == 0) begin
          r.put_error = 1'b1;
        end else begin
          if (mark) dirty[slot] = 1'b1;
          ref_cnt[slot] = ref_cnt[slot] - 1'b1;
          if (ref_cnt[slot] == 0) begin
            r.slot_freed = 1'b1;
            if (dirty[slot]) begin
              r.write_back   = 1'b1;
              r.disk_block   = block_of(ino_tag[slot]);
              r.block_offset = offset_of(ino_tag[slot]);
            end
            dirty[slot] = 1'b0;
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        err_count++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_v, act_v);
      end
    endfunction

    // Compares one result transaction against the oldest prediction.
    function void check_result(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      e = expected_results.pop_front();
      compare_field("result_slot", e.result_slot, got.result_slot);
      compare_field("hit", e.hit, got.hit);
      compare_field("load_needed", e.load_needed, got.load_needed);
      compare_field("table_full", e.table_full, got.table_full);
      compare_field("write_back", e.write_back, got.write_back);
      compare_field("slot_freed", e.slot_freed, got.slot_freed);
      compare_field("put_error", e.put_error, got.put_error);
      compare_field("disk_block", e.disk_block, got.disk_block);
      compare_field("block_offset", e.block_offset, got.block_offset);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [START_W-1:0]   cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [DEV_W-1:0]     device_id_i;
  logic [INO_W-1:0]     inode_number_i;
  logic [SLOT_IN_W-1:0] slot_index_i;
  logic                 mark_dirty_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [SLOT_IN_W-1:0] result_slot_o;
  logic                 hit_o;
  logic                 load_needed_o;
  logic                 table_full_o;
  logic                 write_back_o;
  logic                 slot_freed_o;
  logic                 put_error_o;
  logic [BLK_W-1:0]     disk_block_o;
  logic [OFF_W-1:0]     block_offset_o;

  inode_cache_scoreboard sb;
  int unsigned           tx_idle_pct;
  int unsigned           rx_idle_pct;
  int unsigned           rx_hold_request;
  int unsigned           rx_hold_left;
  int unsigned           cycle_count;
  logic [DEV_W-1:0]      pool_dev [POOL_SIZE];
  logic [INO_W-1:0]      pool_ino [POOL_SIZE];

  refcounted_inode_cache_table_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .device_id_i    (device_id_i),
    .inode_number_i (inode_number_i),
    .slot_index_i   (slot_index_i),
    .mark_dirty_i   (mark_dirty_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_slot_o  (result_slot_o),
    .hit_o          (hit_o),
    .load_needed_o  (load_needed_o),
    .table_full_o   (table_full_o),
    .write_back_o   (write_back_o),
    .slot_freed_o   (slot_freed_o),
    .put_error_o    (put_error_o),
    .disk_block_o   (disk_block_o),
    .block_offset_o (block_offset_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit in case the block stops responding.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result-side ready: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_request != 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every result transaction is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({result_slot_o, hit_o, load_needed_o, table_full_o, write_back_o,
                       slot_freed_o, put_error_o, disk_block_o, block_offset_o});
  end

  // Offers one request, with random idle cycles first, and waits for its acceptance.
  task automatic send_request(logic rt, logic [DEV_W-1:0] dev, logic [INO_W-1:0] ino,
                              logic [SLOT_IN_W-1:0] slot, logic mark);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    req_type_i     = rt;
    device_id_i    = dev;
    inode_number_i = ino;
    slot_index_i   = slot;
    mark_dirty_i   = mark;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(rt, dev, ino, slot, mark);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Unused fields of a get or a put carry random values.
  task automatic send_get(logic [DEV_W-1:0] dev, logic [INO_W-1:0] ino);
    send_request(REQ_GET, dev, ino, SLOT_IN_W'($urandom), 1'($urandom));
  endtask

  task automatic send_put(logic [SLOT_IN_W-1:0] slot, logic mark);
    send_request(REQ_PUT, DEV_W'($urandom), INO_W'($urandom), slot, mark);
  endtask

  // Stops offering requests until every predicted result has arrived.
  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
    @(posedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    @(negedge clk_i);
  endtask

  // Register write, done only with the table idle.
  task automatic write_table_start(logic [START_W-1:0] value);
    wait_results_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.table_start = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Releases every reference still held so the table ends up empty.
  task automatic release_all();
    for (int s = 0; s < SLOTS; s++)
      while (sb.ref_cnt[s] != 0) send_put(SLOT_IN_W'(s), 1'($urandom));
  endtask

  // Mixed traffic: mostly gets on a small key pool and puts on live slots.
  task automatic run_random(int unsigned count);
    int unsigned pick;
    int          live;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) begin
        @(posedge clk_i);
        rx_hold_request = HOLD_CYCLES;
        @(negedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        pick = $urandom_range(POOL_SIZE - 1);
        send_get(pool_dev[pick], pool_ino[pick]);
      end else if (pick < 52) begin
        send_get(DEV_W'($urandom), INO_W'($urandom));
      end else if (pick < 92) begin
        live = sb.pick_live_slot();
        if (live < 0) send_put(SLOT_IN_W'($urandom), 1'($urandom));
        else send_put(SLOT_IN_W'(live), 1'($urandom));
      end else begin
        send_put(SLOT_IN_W'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    logic [DEV_W-1:0] sat_dev;
    logic [INO_W-1:0] sat_ino;
    sb              = new();
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_GET;
    device_id_i     = '0;
    inode_number_i  = '0;
    slot_index_i    = '0;
    mark_dirty_i    = 1'b0;
    tx_idle_pct     = 12;
    rx_idle_pct     = 62;
    rx_hold_request = 0;
    rx_hold_left    = 0;
    cycle_count     = 0;
    foreach (pool_dev[i]) begin
      pool_dev[i] = DEV_W'($urandom_range(3));
      pool_ino[i] = INO_W'($urandom);
    end
    pool_ino[0] = '0;
    pool_ino[1] = '1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, with the table start at its reset value.
    send_get(8'h00, 20'h00001);          // first inode, block zero
    send_get(8'hFF, 20'hFFFFF);          // largest device and inode
    send_get(8'h00, 20'h00000);          // inode zero wraps to the last entry
    send_get(8'h00, 20'h00001);          // hit on slot 0
    send_put(6'd0, 1'b1);                // dirty mark kept, slot still held
    send_put(6'd0, 1'b0);                // frees slot 0 with write-back
    send_put(6'd0, 1'b1);                // put on a free slot
    send_put(6'd1, 1'b0);                // frees a clean slot
    send_put(6'd63, 1'b1);               // highest slot, never claimed
    send_get(8'h00, 20'h00001);          // reclaims slot 0, dirty cleared
    send_put(6'd0, 1'b0);                // clean release of the reclaimed slot
    send_get(8'hAA, 20'h55555);
    send_get(8'hAA, 20'hAAAAA);          // same device, other inode
    send_get(8'h55, 20'h55555);          // same inode, other device
    send_put(6'd2, 1'b1);                // write-back of the wrapped inode zero
    release_all();

    // Three phases with different idling and table start settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          set_idling(12, 62);
          write_table_start(16'hFFFF);
        end
        1: begin
          set_idling(62, 12);
          write_table_start(START_W'($urandom));
        end
        default: begin
          set_idling(0, 0);
          write_table_start(16'h0000);
        end
      endcase
      run_random(RANDOM_REQS);
      wait_results_drained();
      // Fill the table with fresh keys, sending more gets than there are slots so some are refused, then empty it.
      repeat (SLOTS + 4) send_get(DEV_W'($urandom), INO_W'($urandom));
      release_all();
      send_put(SLOT_IN_W'($urandom), 1'b1);
      if (phase == 2) begin
        // Drive one reference count past its maximum, then release it fully.
        sat_dev = DEV_W'($urandom);
        sat_ino = INO_W'($urandom);
        repeat (COUNT_MAX + 5) send_get(sat_dev, sat_ino);
        send_put(6'd0, 1'b1);
        release_all();
        send_put(6'd0, 1'b0);
      end
      wait_results_drained();
    end

    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.err_count == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
